@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// When pre holds, post must hold at the next edge.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ sv/tgig_pkg.sv @@
// Types, constants and helpers of the terrain grid index generator.
`default_nettype none
package tgig_pkg;

  localparam int GRIDS_PER_EDGE = 16;
  localparam int EDGE_W = $clog2(GRIDS_PER_EDGE) + 1;  // holds the edge length itself
  localparam int LG_W = 3;
  localparam int IDX_W = 16;
  localparam int CMD_W = 2;
  localparam int POS_W = 4;
  localparam int CNT_W = 3;
  localparam int NUM_IDX = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] CNT_TRI = 3'd3;
  localparam logic [CNT_W-1:0] CNT_QUAD = 3'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAIN  = 2'd0,
    CMD_NORTH = 2'd1,
    CMD_EAST  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RENDER_LG = 2'd0,
    CFG_NORTH_LG  = 2'd1,
    CFG_EAST_LG   = 2'd2,
    CFG_BASE      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LG_W-1:0]  render_lg;
    logic [LG_W-1:0]  north_lg;
    logic [LG_W-1:0]  east_lg;
    logic [IDX_W-1:0] base;
  } cfg_t;

  typedef struct packed {
    logic [NUM_IDX-1:0][IDX_W-1:0] idx;
    logic [CNT_W-1:0]              count;
  } res_t;

  // Vertices along one edge for a given log2 stride; 0 once the stride is too big.
  function automatic logic [EDGE_W-1:0] edge_len(input logic [LG_W-1:0] lg);
    logic [EDGE_W-1:0] full;
    full = EDGE_W'(GRIDS_PER_EDGE);
    return full >> lg;
  endfunction

endpackage
`default_nettype wire

@@ sv/tgig_calc.sv @@
// Index arithmetic for one emit step: main cell, north seam or east seam.
`default_nettype none
module tgig_calc (
  input  tgig_pkg::cfg_t                   cfg_i,
  input  logic [tgig_pkg::CMD_W-1:0]       cmd_i,
  input  logic [tgig_pkg::POS_W-1:0]       row_i,
  input  logic [tgig_pkg::POS_W-1:0]       step_i,
  output tgig_pkg::res_t                   res_o
);
  import tgig_pkg::*;

  logic [EDGE_W-1:0]     l, lf, lfn, v_m1;
  logic [2*EDGE_W-1:0]   sq;
  logic [IDX_W-1:0]      l16, h16, i16, q16, c16, jv16, j1v16;
  logic [POS_W+EDGE_W-1:0] jv;
  logic [IDX_W-1:0]      mvc, svc_n, seam_base, base;
  logic [LG_W-1:0]       nlg;
  logic                  north;
  logic [NUM_IDX-1:0][IDX_W-1:0] rel;
  logic [CNT_W-1:0]      n;

  always_comb begin
    l     = edge_len(cfg_i.render_lg);
    l16   = IDX_W'(l);
    i16   = IDX_W'(step_i);
    q16   = IDX_W'(step_i >> 1);
    sq    = (2*EDGE_W)'(l) * (2*EDGE_W)'(l);
    mvc   = (l >= EDGE_W'(2)) ? IDX_W'(sq) : '0;

    // North strip size sets where the east strip starts.
    lfn = edge_len(cfg_i.north_lg);
    if (cfg_i.north_lg == cfg_i.render_lg) begin
      svc_n = (l16 << 1) + 16'd1;
    end else if (cfg_i.north_lg > cfg_i.render_lg) begin
      svc_n = l16 + (l16 >> 1) + 16'd1;
    end else begin
      svc_n = IDX_W'(lfn) + IDX_W'(lfn >> 1) + 16'd1;
    end

    north     = (cmd_i == CMD_NORTH);
    nlg       = north ? cfg_i.north_lg : cfg_i.east_lg;
    lf        = edge_len(nlg);
    h16       = IDX_W'(lf >> 1);
    seam_base = cfg_i.base + mvc + (north ? 16'd0 : svc_n);

    v_m1  = l - EDGE_W'(1);
    jv    = (POS_W+EDGE_W)'(row_i) * (POS_W+EDGE_W)'(l);
    jv16  = IDX_W'(jv);
    j1v16 = jv16 + l16;
    c16   = '0;
    rel   = '0;
    n     = CNT_NONE;
    base  = cfg_i.base;

    unique case (cmd_i)
      CMD_MAIN: begin
        if (l >= EDGE_W'(2) && EDGE_W'(row_i) < v_m1 && EDGE_W'(step_i) < v_m1) begin
          n = CNT_QUAD;
          if (row_i[0]) begin
            // odd rows run east to west
            c16    = IDX_W'(v_m1) - i16;
            rel[0] = c16 - 16'd1 + jv16;
            rel[1] = c16 + j1v16;
            rel[2] = c16 - 16'd1 + j1v16;
            rel[3] = c16 - 16'd1 + jv16;
            rel[4] = c16 + jv16;
            rel[5] = c16 + j1v16;
          end else begin
            c16    = i16;
            rel[0] = c16 + jv16;
            rel[1] = c16 + 16'd1 + j1v16;
            rel[2] = c16 + j1v16;
            rel[3] = c16 + jv16;
            rel[4] = c16 + 16'd1 + jv16;
            rel[5] = c16 + 16'd1 + j1v16;
          end
        end
      end
      CMD_NORTH, CMD_EAST: begin
        base = seam_base;
        if (nlg == cfg_i.render_lg) begin
          if (i16 < l16) begin
            n = (i16 != l16 - 16'd1) ? CNT_QUAD : CNT_TRI;
            rel[0] = i16;
            rel[3] = i16;
            if (north) begin
              rel[1] = l16 + i16 + 16'd1;
              rel[2] = l16 + i16;
              rel[4] = i16 + 16'd1;
              rel[5] = l16 + i16 + 16'd1;
            end else begin
              rel[1] = l16 + i16;
              rel[2] = l16 + i16 + 16'd1;
              rel[4] = l16 + i16 + 16'd1;
              rel[5] = i16 + 16'd1;
            end
          end
        end else if (nlg > cfg_i.render_lg) begin
          // coarser neighbor: two of ours per one of theirs
          if (i16 < l16) begin
            if (!step_i[0]) begin
              n      = CNT_QUAD;
              rel[0] = i16;
              rel[3] = i16 + 16'd1;
              if (north) begin
                rel[1] = i16 + 16'd1;
                rel[2] = l16 + q16;
                rel[4] = l16 + q16 + 16'd1;
                rel[5] = l16 + q16;
              end else begin
                rel[1] = l16 + q16;
                rel[2] = i16 + 16'd1;
                rel[4] = l16 + q16;
                rel[5] = l16 + q16 + 16'd1;
              end
            end else if (i16 + 16'd1 < l16) begin
              n      = CNT_TRI;
              rel[0] = i16;
              rel[1] = north ? i16 + 16'd1 : l16 + q16 + 16'd1;
              rel[2] = north ? l16 + q16 + 16'd1 : i16 + 16'd1;
            end
          end
        end else begin
          // finer neighbor: strip walks the neighbor's vertices
          if (i16 < IDX_W'(lf)) begin
            rel[0] = h16 + i16;
            if (step_i[0] && (i16 + 16'd2 < IDX_W'(lf))) begin
              n      = CNT_QUAD;
              rel[3] = h16 + i16;
              if (north) begin
                rel[1] = q16;
                rel[2] = q16 + 16'd1;
                rel[4] = q16 + 16'd1;
                rel[5] = h16 + i16 + 16'd1;
              end else begin
                rel[1] = q16 + 16'd1;
                rel[2] = q16;
                rel[4] = h16 + i16 + 16'd1;
                rel[5] = q16 + 16'd1;
              end
            end else begin
              n      = CNT_TRI;
              rel[1] = north ? q16 : h16 + i16 + 16'd1;
              rel[2] = north ? h16 + i16 + 16'd1 : q16;
            end
          end
        end
      end
      default: begin
        n = CNT_NONE;
      end
    endcase

    for (int k = 0; k < NUM_IDX; k++) begin
      res_o.idx[k] = (CNT_W'(k) < n) ? base + rel[k] : '0;
    end
    res_o.count = n;
  end

endmodule
`default_nettype wire

@@ sv/terrain_grid_index_generator.sv @@
// Top level of the terrain grid index generator: handshake, config and pipeline.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o | command_i, row_i, step_i
//  out     | output    | out_valid_o/out_stall_i | index_a_o..index_f_o, index_count_o
//  cfg     | input     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// Two register stages: an input register, then the index arithmetic feeding
// the result register. One transaction per cycle is sustained while the output
// is not stalled; the index logic is a single combinational pass between them.
// Reset (rst_ni low, async) empties both stages and clears all config to 0.
// A stalled output holds; the input register keeps filling until both stages
// hold a transaction, then in_stall_o rises. No reset clearing pass.
`default_nettype none
module terrain_grid_index_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tgig_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tgig_pkg::IDX_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tgig_pkg::CMD_W-1:0]         command_i,
  input  logic [tgig_pkg::POS_W-1:0]         row_i,
  input  logic [tgig_pkg::POS_W-1:0]         step_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tgig_pkg::IDX_W-1:0]         index_a_o,
  output logic [tgig_pkg::IDX_W-1:0]         index_b_o,
  output logic [tgig_pkg::IDX_W-1:0]         index_c_o,
  output logic [tgig_pkg::IDX_W-1:0]         index_d_o,
  output logic [tgig_pkg::IDX_W-1:0]         index_e_o,
  output logic [tgig_pkg::IDX_W-1:0]         index_f_o,
  output logic [tgig_pkg::CNT_W-1:0]         index_count_o
);
  import tgig_pkg::*;
`include "assert_macros.svh"

  cfg_t cfg_q;

  logic              s1_valid_q;
  logic [CMD_W-1:0]  s1_cmd_q;
  logic [POS_W-1:0]  s1_row_q, s1_step_q;
  logic              out_valid_q;
  res_t              res_d, res_q;

  logic out_load, s1_load;

  // Result register takes a new value whenever it is empty or being drained.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || out_load;
  assign in_stall_o = !s1_load;

  // Config writes; stride fields keep only the low LG_W bits, with no range check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RENDER_LG: cfg_q.render_lg <= cfg_data_i[LG_W-1:0];
        CFG_NORTH_LG:  cfg_q.north_lg  <= cfg_data_i[LG_W-1:0];
        CFG_EAST_LG:   cfg_q.east_lg   <= cfg_data_i[LG_W-1:0];
        CFG_BASE:      cfg_q.base      <= cfg_data_i;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_cmd_q  <= command_i;
      s1_row_q  <= row_i;
      s1_step_q <= step_i;
    end
    if (out_load && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  tgig_calc u_calc (
    .cfg_i  (cfg_q),
    .cmd_i  (s1_cmd_q),
    .row_i  (s1_row_q),
    .step_i (s1_step_q),
    .res_o  (res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign index_a_o     = res_q.idx[0];
  assign index_b_o     = res_q.idx[1];
  assign index_c_o     = res_q.idx[2];
  assign index_d_o     = res_q.idx[3];
  assign index_e_o     = res_q.idx[4];
  assign index_f_o     = res_q.idx[5];
  assign index_count_o = res_q.count;

  // Only 0, 3 or 6 indices are ever valid.
  `ASSERT_ALWAYS(a_count_legal, !out_valid_q || res_q.count == CNT_NONE || res_q.count == CNT_TRI || res_q.count == CNT_QUAD, "illegal index count")
  // Slots past the count read as zero.
  `ASSERT_ALWAYS(a_unused_zero, !out_valid_q || res_q.count == CNT_QUAD || (res_q.idx[3] == '0 && res_q.idx[4] == '0 && res_q.idx[5] == '0), "unused index slot not zero")
  // Input side only stalls with both stages full.
  `ASSERT_ALWAYS(a_stall_full, !in_stall_o || (s1_valid_q && out_valid_q), "stall with free stage")
  // A held input-stage transaction is not dropped.
  `ASSERT_NEXT(a_s1_held, s1_valid_q && !s1_load, s1_valid_q, "input stage lost transaction")

endmodule
`default_nettype wire
